// ----- src/hhbp_pkg.sv -----
package hhbp_pkg;

	// Parser states, one-hot
	typedef enum logic [8:0] {
		ST_START  = 9'b000000001,
		ST_KEY    = 9'b000000010,
		ST_COLON  = 9'b000000100,
		ST_SPACE  = 9'b000001000,
		ST_VALUE  = 9'b000010000,
		ST_CR     = 9'b000100000,
		ST_LF     = 9'b001000000,
		ST_END_CR = 9'b010000000,
		ST_BODY   = 9'b100000000
	} state_t;

	localparam int unsigned OFFSET_W = 10;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [OFFSET_W-1:0] MAX_VALUE_OFFSET_RESET = OFFSET_W'(255);

	// Byte classes
	localparam logic [1:0] CLS_DELIM = 2'd0;
	localparam logic [1:0] CLS_KEY   = 2'd1;
	localparam logic [1:0] CLS_VALUE = 2'd2;
	localparam logic [1:0] CLS_BODY  = 2'd3;

	// Error kinds
	localparam logic [2:0] ERR_NONE         = 3'd0;
	localparam logic [2:0] ERR_KEY_CRLF     = 3'd1;
	localparam logic [2:0] ERR_NO_SPACE     = 3'd2;
	localparam logic [2:0] ERR_TOO_LONG     = 3'd3;
	localparam logic [2:0] ERR_CR_NO_LF     = 3'd4;
	localparam logic [2:0] ERR_END_CR_NO_LF = 3'd5;

	typedef struct packed {
		logic [7:0] byte_echo;
		logic [1:0] byte_class;
		logic       key_first;
		logic       value_first;
		logic       pair_done;
		logic       headers_done;
		logic [2:0] error_kind;
	} result_t;

	typedef struct packed {
		state_t              state;
		logic [OFFSET_W-1:0] value_offset;
		logic [2:0]          error_latch;
	} parse_ctx_t;

endpackage

// ----- src/http_header_byte_parser_core.sv -----
// Channel  | Handshake             | Payload
// ---------+-----------------------+-------------------------------------------
// input    | in_valid / in_stall   | action, data_byte
// output   | out_valid / out_stall | byte_echo, byte_class, key_first,
//          |                       | value_first, pair_done, headers_done,
//          |                       | error_kind
// config   | cfg_wr_en             | cfg_wr_data (max_value_offset)
//
// One request per cycle sustained while out_stall is low; a request passes the input
// register and then the result register, with one state update per request in between.
// arst_n clears the parser state, the value offset, the error latch, both
// valid flags, and loads max_value_offset with 255.
// out_stall holds the result register; the input register then fills and
// in_stall rises only while it is occupied and cannot advance.
module http_header_byte_parser_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic [7:0]                    data_byte,
	input  logic                          cfg_wr_en,
	input  logic [hhbp_pkg::OFFSET_W-1:0] cfg_wr_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    byte_echo,
	output logic [1:0]                    byte_class,
	output logic                          key_first,
	output logic                          value_first,
	output logic                          pair_done,
	output logic                          headers_done,
	output logic [2:0]                    error_kind
);

	logic                          valid_s1;
	logic                          action_s1;
	logic [7:0]                    byte_s1;
	logic                          valid_s2;
	hhbp_pkg::result_t             res_s2;
	hhbp_pkg::result_t             res_next;
	hhbp_pkg::parse_ctx_t          ctx_q;
	hhbp_pkg::parse_ctx_t          ctx_next;
	logic [hhbp_pkg::OFFSET_W-1:0] max_value_offset_q;
	logic                          s2_free;
	logic                          advance;
	logic                          accept;

	// result register drains or is empty -> stage 1 may move
	assign s2_free  = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_value_offset_q <= hhbp_pkg::MAX_VALUE_OFFSET_RESET;
		end else if (cfg_wr_en) begin
			max_value_offset_q <= cfg_wr_data;
		end
	end

	// Input register: load on accept, drop on advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			byte_s1   <= data_byte;
		end
	end

	hhbp_step u_step (
		.action           (action_s1),
		.data_byte        (byte_s1),
		.max_value_offset (max_value_offset_q),
		.ctx              (ctx_q),
		.ctx_next         (ctx_next),
		.res              (res_next)
	);

	// Parser context advances once per request leaving stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.state        <= hhbp_pkg::ST_START;
			ctx_q.value_offset <= '0;
			ctx_q.error_latch  <= hhbp_pkg::ERR_NONE;
		end else if (advance) begin
			ctx_q <= ctx_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid    = valid_s2;
	assign byte_echo    = res_s2.byte_echo;
	assign byte_class   = res_s2.byte_class;
	assign key_first    = res_s2.key_first;
	assign value_first  = res_s2.value_first;
	assign pair_done    = res_s2.pair_done;
	assign headers_done = res_s2.headers_done;
	assign error_kind   = res_s2.error_kind;

endmodule

// ----- src/hhbp_step.sv -----
module hhbp_step (
	input  logic                         action,
	input  logic [7:0]                   data_byte,
	input  logic [hhbp_pkg::OFFSET_W-1:0] max_value_offset,
	input  hhbp_pkg::parse_ctx_t         ctx,
	output hhbp_pkg::parse_ctx_t         ctx_next,
	output hhbp_pkg::result_t            res
);

	logic [2:0] err;

	always_comb begin
		ctx_next        = ctx;
		err             = hhbp_pkg::ERR_NONE;
		res             = '0;
		res.byte_echo   = data_byte;
		if (action) begin
			// restart: clear everything, echo zero
			ctx_next.state        = hhbp_pkg::ST_START;
			ctx_next.value_offset = '0;
			ctx_next.error_latch  = hhbp_pkg::ERR_NONE;
			res.byte_echo         = '0;
		end else if (ctx.error_latch != hhbp_pkg::ERR_NONE) begin
			// hold state, repeat latched error
			res.error_kind = ctx.error_latch;
		end else begin
			unique case (ctx.state)
				hhbp_pkg::ST_KEY: begin
					if (data_byte == hhbp_pkg::CH_COLON) begin
						ctx_next.state = hhbp_pkg::ST_COLON;
					end else if (data_byte == hhbp_pkg::CH_CR || data_byte == hhbp_pkg::CH_LF) begin
						err = hhbp_pkg::ERR_KEY_CRLF;
					end else begin
						res.byte_class = hhbp_pkg::CLS_KEY;
					end
				end
				hhbp_pkg::ST_COLON: begin
					if (data_byte == hhbp_pkg::CH_SPACE) begin
						ctx_next.state = hhbp_pkg::ST_SPACE;
					end else begin
						err = hhbp_pkg::ERR_NO_SPACE;
					end
				end
				hhbp_pkg::ST_SPACE: begin
					// any byte opens the value, CR included
					res.byte_class        = hhbp_pkg::CLS_VALUE;
					res.value_first       = 1'b1;
					ctx_next.value_offset = '0;
					ctx_next.state        = hhbp_pkg::ST_VALUE;
				end
				hhbp_pkg::ST_VALUE: begin
					if (data_byte == hhbp_pkg::CH_CR) begin
						ctx_next.state = hhbp_pkg::ST_CR;
					end else if (ctx.value_offset >= max_value_offset) begin
						err = hhbp_pkg::ERR_TOO_LONG;
					end else begin
						ctx_next.value_offset = ctx.value_offset + 1'b1;
						res.byte_class        = hhbp_pkg::CLS_VALUE;
					end
				end
				hhbp_pkg::ST_CR: begin
					if (data_byte == hhbp_pkg::CH_LF) begin
						res.pair_done  = 1'b1;
						ctx_next.state = hhbp_pkg::ST_LF;
					end else begin
						err = hhbp_pkg::ERR_CR_NO_LF;
					end
				end
				hhbp_pkg::ST_LF: begin
					if (data_byte == hhbp_pkg::CH_CR) begin
						ctx_next.state = hhbp_pkg::ST_END_CR;
					end else begin
						res.byte_class = hhbp_pkg::CLS_KEY;
						res.key_first  = 1'b1;
						ctx_next.state = hhbp_pkg::ST_KEY;
					end
				end
				hhbp_pkg::ST_END_CR: begin
					if (data_byte == hhbp_pkg::CH_LF) begin
						res.headers_done = 1'b1;
						ctx_next.state   = hhbp_pkg::ST_BODY;
					end else begin
						err = hhbp_pkg::ERR_END_CR_NO_LF;
					end
				end
				hhbp_pkg::ST_BODY: begin
					res.byte_class = hhbp_pkg::CLS_BODY;
				end
				default: begin
					// start: skip leading CR and LF
					if (data_byte != hhbp_pkg::CH_CR && data_byte != hhbp_pkg::CH_LF) begin
						res.byte_class = hhbp_pkg::CLS_KEY;
						res.key_first  = 1'b1;
						ctx_next.state = hhbp_pkg::ST_KEY;
					end else begin
						ctx_next.state = hhbp_pkg::ST_START;
					end
				end
			endcase
			ctx_next.error_latch = err;
			res.error_kind       = err;
		end
	end

endmodule

// ----- src/hhbp_checker.sv -----
module hhbp_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] byte_echo,
	input  logic [1:0] byte_class,
	input  logic       key_first,
	input  logic       value_first,
	input  logic       pair_done,
	input  logic       headers_done,
	input  logic [2:0] error_kind
);

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(byte_echo) && $stable(error_kind)
		&& $stable(byte_class))
		else $error("result changed while stalled");

	// An error byte carries no tag
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_kind != hhbp_pkg::ERR_NONE |->
		byte_class == hhbp_pkg::CLS_DELIM && !key_first && !value_first
		&& !pair_done && !headers_done)
		else $error("error result carries tags");

	// Key start is a key byte
	a_key_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_first |-> byte_class == hhbp_pkg::CLS_KEY && !value_first)
		else $error("key start not tagged as key");

	// Value start is a value byte
	a_value_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && value_first |-> byte_class == hhbp_pkg::CLS_VALUE)
		else $error("value start not tagged as value");

	// Line ends fall on LF delimiters
	a_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (pair_done || headers_done) |->
		byte_echo == hhbp_pkg::CH_LF && byte_class == hhbp_pkg::CLS_DELIM
		&& !(pair_done && headers_done))
		else $error("line end not on LF");

endmodule

bind http_header_byte_parser_core hhbp_checker u_hhbp_checker (.*);
